FILE: hdl/tcw_pkg.sv
// Shared types and constants for the text console cursor writer.
`default_nettype none

package tcw_pkg;

    // Fixed field widths of the channel words.
    localparam int CHAR_W    = 8;
    localparam int IN_ADDR_W = 11;
    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 5;

    // Operation codes.
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Character codes with special meaning.
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic sweep;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
        logic clear_pend;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: hdl/tcw_if.sv
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface tcw_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [tcw_pkg::CHAR_W-1:0]    character;
    logic [tcw_pkg::IN_ADDR_W-1:0] cell_address;

    modport source (output valid, output opcode, output character, output cell_address,
                    input ready);
    modport sink   (input valid, input opcode, input character, input cell_address,
                    output ready);
endinterface

interface tcw_out_if;
    logic                         valid;
    logic                         ready;
    logic                         cell_written;
    logic [tcw_pkg::IN_ADDR_W-1:0] written_address;
    logic [tcw_pkg::CHAR_W-1:0]    written_char;
    logic [tcw_pkg::OUT_COL_W-1:0] cursor_column;
    logic [tcw_pkg::OUT_ROW_W-1:0] cursor_row;
    logic                         screen_cleared;
    logic [tcw_pkg::CHAR_W-1:0]    read_char;

    modport source (output valid, output cell_written, output written_address,
                    output written_char, output cursor_column, output cursor_row,
                    output screen_cleared, output read_char, input ready);
    modport sink   (input valid, input cell_written, input written_address,
                    input written_char, input cursor_column, input cursor_row,
                    input screen_cleared, input read_char, output ready);
endinterface

`default_nettype wire

FILE: hdl/tcw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tcw_ctrl.sv
// Controller state machine: clearing sweep, idle and execute sequencing.
`default_nettype none

module tcw_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_dp_cmd         o_cmd
);

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;

    // State register; reset starts with a sweep that fills the store with spaces.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::ST_CLEAR: begin
                if (i_status.sweep_last) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (i_in_valid && i_status.out_free) begin
                    n_state = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC: begin
                if (i_status.clear_pend) begin
                    n_state = tcw_pkg::ST_CLEAR;
                end else begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs: a word is taken only in idle and only when the result register can be refilled.
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.sweep    = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            tcw_pkg::ST_CLEAR: begin
                o_cmd.sweep = 1'b1;
            end
            tcw_pkg::ST_IDLE: begin
                o_in_ready = i_status.out_free;
            end
            tcw_pkg::ST_EXEC: begin
                o_cmd.load_out = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.accept = o_in_ready && i_in_valid;
    end

    // An accepted word is always followed by the execute state.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == tcw_pkg::ST_EXEC))
        else $error("accepted word not followed by execute");

    // The execute state is never followed directly by execute again.
    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_EXEC) |=> (r_state != tcw_pkg::ST_EXEC))
        else $error("execute state held for two cycles");

endmodule

`default_nettype wire

FILE: hdl/tcw_dp.sv
// Datapath: cursor registers, cell addressing, character store and result register.
`default_nettype none

module tcw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tcw_pkg::t_dp_cmd              i_cmd,
    output tcw_pkg::t_dp_status                o_status,
    input  wire logic                          i_opcode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    i_character,
    input  wire logic [tcw_pkg::IN_ADDR_W-1:0] i_cell_address,
    tcw_out_if.source                          o_out
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int IAW   = (AW > tcw_pkg::IN_ADDR_W) ? AW : tcw_pkg::IN_ADDR_W;
    localparam int OCW   = (CW > tcw_pkg::OUT_COL_W) ? CW : tcw_pkg::OUT_COL_W;
    localparam int ORW   = (RW > tcw_pkg::OUT_ROW_W) ? RW : tcw_pkg::OUT_ROW_W;

    // Cursor and sweep state.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [AW-1:0] r_sweep_idx;

    // Item state held from the accept cycle to the execute cycle.
    logic                      r_wrote;
    logic [AW-1:0]             r_waddr;
    logic [tcw_pkg::CHAR_W-1:0] r_wchar;
    logic                      r_cleared;
    logic                      r_is_read;
    logic                      r_rd_ok;

    // Result register.
    logic                         r_out_valid;
    logic                         r_o_written;
    logic [tcw_pkg::IN_ADDR_W-1:0] r_o_waddr;
    logic [tcw_pkg::CHAR_W-1:0]    r_o_wchar;
    logic [tcw_pkg::OUT_COL_W-1:0] r_o_col;
    logic [tcw_pkg::OUT_ROW_W-1:0] r_o_row;
    logic                         r_o_cleared;
    logic [tcw_pkg::CHAR_W-1:0]    r_o_rchar;

    // Combinational next values.
    logic [AW-1:0]             cur_idx;
    logic [CW:0]               n_col;
    logic [RW:0]               n_row;
    logic                      n_wrote;
    logic [AW-1:0]             n_waddr;
    logic [tcw_pkg::CHAR_W-1:0] n_wchar;
    logic                      n_cleared;
    logic                      is_put;
    logic [IAW-1:0]            rd_addr_ext;
    logic [IAW-1:0]            wa_ext;
    logic [OCW-1:0]            col_ext;
    logic [ORW-1:0]            row_ext;
    logic [tcw_pkg::CHAR_W-1:0] rd_data;

    // Linear index of the cell under the cursor.
    assign cur_idx = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign is_put  = (i_opcode == tcw_pkg::OP_PUT) && (i_character != tcw_pkg::CH_NUL);

    // Cursor movement, cell write and wrap / clear decision for a put.
    always_comb begin
        n_col     = {1'b0, r_col};
        n_row     = {1'b0, r_row};
        n_wrote   = 1'b0;
        n_waddr   = cur_idx;
        n_wchar   = i_character;
        n_cleared = 1'b0;
        if (is_put) begin
            if (i_character == tcw_pkg::CH_NEWLINE || i_character == tcw_pkg::CH_RETURN) begin
                n_col = '0;
                n_row = n_row + 1'b1;
            end else if (i_character == tcw_pkg::CH_SPACE) begin
                n_col = n_col + 1'b1;
            end else if (i_character == tcw_pkg::CH_BACKSPACE) begin
                if (r_col != '0) begin
                    n_col   = n_col - 1'b1;
                    n_wrote = 1'b1;
                    n_waddr = cur_idx - AW'(1);
                    n_wchar = tcw_pkg::CH_SPACE;
                end
            end else begin
                n_wrote = 1'b1;
                n_col   = n_col + 1'b1;
            end
            if (n_col >= (CW+1)'(COLUMNS)) begin
                n_col = '0;
                n_row = n_row + 1'b1;
            end
            if (n_row >= (RW+1)'(ROWS)) begin
                n_col     = '0;
                n_row     = '0;
                n_cleared = 1'b1;
            end
        end
    end

    // Read address taken to the store's width.
    assign rd_addr_ext = IAW'(i_cell_address);

    // Character store; the write port is shared by the clearing sweep and puts.
    tcw_ram #(
        .WIDTH (tcw_pkg::CHAR_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.sweep || (i_cmd.accept && n_wrote)),
        .i_wr_addr (i_cmd.sweep ? r_sweep_idx : n_waddr),
        .i_wr_data (i_cmd.sweep ? tcw_pkg::CH_SPACE : n_wchar),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (rd_addr_ext[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Sweep counter and cursor registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_idx <= '0;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            if (i_cmd.sweep) begin
                r_sweep_idx <= o_status.sweep_last ? '0 : r_sweep_idx + 1'b1;
            end
            if (i_cmd.accept) begin
                r_col <= n_col[CW-1:0];
                r_row <= n_row[RW-1:0];
            end
        end
    end

    // Item state captured at accept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_wrote   <= n_wrote;
            r_waddr   <= n_waddr;
            r_wchar   <= n_wchar;
            r_cleared <= n_cleared;
            r_is_read <= (i_opcode == tcw_pkg::OP_READ);
            r_rd_ok   <= (32'(i_cell_address) < CELLS);
        end
    end

    // Result word fields taken to the channel widths.
    assign wa_ext  = IAW'(r_waddr);
    assign col_ext = OCW'(r_col);
    assign row_ext = ORW'(r_row);

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_written <= r_wrote;
            r_o_waddr   <= r_wrote ? wa_ext[tcw_pkg::IN_ADDR_W-1:0] : '0;
            r_o_wchar   <= r_wrote ? r_wchar : '0;
            r_o_col     <= col_ext[tcw_pkg::OUT_COL_W-1:0];
            r_o_row     <= row_ext[tcw_pkg::OUT_ROW_W-1:0];
            r_o_cleared <= r_cleared;
            r_o_rchar   <= (r_is_read && r_rd_ok) ? rd_data : '0;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.cell_written    = r_o_written;
    assign o_out.written_address = r_o_waddr;
    assign o_out.written_char    = r_o_wchar;
    assign o_out.cursor_column   = r_o_col;
    assign o_out.cursor_row      = r_o_row;
    assign o_out.screen_cleared  = r_o_cleared;
    assign o_out.read_char       = r_o_rchar;

    // Status to the controller.
    assign o_status.sweep_last = (r_sweep_idx == AW'(CELLS - 1));
    assign o_status.clear_pend = r_cleared;
    assign o_status.out_free   = !r_out_valid || o_out.ready;

    // The result register is never overwritten while it still holds a word.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || o_out.ready))
        else $error("result register overwritten");

    // A screen clear homes the cursor.
    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && n_cleared) |=> (r_col == '0 && r_row == '0))
        else $error("cursor not homed after clear");

    // The cursor always stays on the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> (32'(r_col) < COLUMNS && 32'(r_row) < ROWS))
        else $error("cursor left the screen");

endmodule

`default_nettype wire

FILE: hdl/text_console_cursor_writer.sv
// Top level of the text console cursor writer: controller, datapath and channels.
//
// Each input word either puts one character at the cursor or reads one cell of the
// COLUMNS by ROWS character store. In the cycle a word is accepted the store is
// written or read through its single write port and registered read port, and in the
// next cycle the result word is loaded into the output register, so a new word is not
// taken until the previous word has passed through execute. A new word is accepted
// while the previous result waits if the result is being taken that cycle.
// After reset, and after any put that runs past the last row, the store is swept back
// to spaces one cell per cycle over all COLUMNS*ROWS cells (2000 by default), during
// which no input word is accepted.
`default_nettype none

module text_console_cursor_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcw_in_if.sink    i_in,
    tcw_out_if.source o_out
);

    tcw_pkg::t_dp_cmd    cmd;
    tcw_pkg::t_dp_status status;

    // Sequencing of sweeps and items.
    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Cursor, store and result register.
    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_opcode       (i_in.opcode),
        .i_character    (i_in.character),
        .i_cell_address (i_in.cell_address),
        .o_out          (o_out)
    );

endmodule

`default_nettype wire
